// ----- rtl/fsfd_pkg.sv -----
package fsfd_pkg;

  localparam int unsigned LenW  = 10;
  localparam int unsigned BitsW = 40;
  localparam int unsigned NumBytes = BitsW / 8;

  localparam logic [LenW-1:0] LenMin = 10'd39;
  localparam logic [LenW-1:0] LenMax = 10'd43;

  localparam logic [7:0] CrcPoly  = 8'h07;
  localparam logic [7:0] CrcFix   = 8'h80;
  localparam logic [7:0] MagMask  = 8'h7f;
  localparam logic [7:0] AllOnes  = 8'hff;

  typedef enum logic [1:0] {
    OUT_VALID    = 2'd0,
    OUT_BAD_LEN  = 2'd1,
    OUT_STUCK    = 2'd2,
    OUT_CRC_FAIL = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [LenW-1:0]  row_length;
    logic [BitsW-1:0] row_bits;
  } fsfd_in_t;

  typedef struct packed {
    outcome_e           outcome;
    logic               crc_repaired;
    logic [15:0]        node_id;
    logic [1:0]         channel;
    logic               batt_good;
    logic [6:0]         status_bits;
    logic signed [7:0]  temp_degf;
  } fsfd_out_t;

  function automatic logic [7:0] rev_byte(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  localparam logic [7:0] CrcPolyRefl = rev_byte(CrcPoly);

  // One byte through the reflected CRC-8 register.
  function automatic logic [7:0] crc8_byte(input logic [7:0] rem_in, input logic [7:0] data);
    logic [7:0] rem;
    rem = rem_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (rem[0]) begin
        rem = (rem >> 1) ^ CrcPolyRefl;
      end else begin
        rem = rem >> 1;
      end
    end
    return rem;
  endfunction

endpackage

// ----- rtl/fridge_sensor_frame_decoder_unit.sv -----
// Channel | Direction | Handshake             | Payload
// row     | in        | in_valid_i/in_stall_o | in_data_i  (fsfd_in_t)
// result  | out       | out_valid_o/out_stall_i | out_data_o (fsfd_out_t)
//
// One row per cycle while the result side is not stalled; a row passes the
// input register, then is decoded into the result register.
// Reset clears both valid flags; payload registers are left as they are.
// A stalled result holds; the input register still takes a row while the
// result waits and stalls only once both stages are full.
module fridge_sensor_frame_decoder_unit import fsfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  fsfd_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output fsfd_out_t out_data_o
);

  logic      row_valid_q;
  fsfd_in_t  row_q;
  logic      res_valid_q;
  fsfd_out_t res_q;
  fsfd_out_t res_d;
  logic      res_en;
  logic      row_en;

  assign res_en     = ~res_valid_q | ~out_stall_i;
  assign row_en     = ~row_valid_q | res_en;
  assign in_stall_o = ~row_en;

  fsfd_decode u_decode (
    .row_i (row_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (row_en) begin
        row_valid_q <= in_valid_i;
      end
      if (res_en) begin
        res_valid_q <= row_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_en && in_valid_i) begin
      row_q <= in_data_i;
    end
    if (res_en && row_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

// ----- rtl/fsfd_decode.sv -----
module fsfd_decode import fsfd_pkg::*; (
  input  fsfd_in_t  row_i,
  output fsfd_out_t res_o
);

  logic [7:0] raw [NumBytes];
  logic [7:0] br  [NumBytes];
  logic [7:0] crc_calc;
  logic       len_bad;
  logic       stuck;
  logic [6:0] mag;
  logic [7:0] mag_ext;

  always_comb begin
    for (int i = 0; i < NumBytes; i++) begin
      raw[i] = row_i.row_bits[BitsW-1-8*i -: 8];
      br[i]  = rev_byte(raw[i]);
    end
  end

  always_comb begin
    crc_calc = '0;
    for (int i = 0; i < NumBytes - 1; i++) begin
      crc_calc = crc8_byte(crc_calc, br[i]);
    end
  end

  assign len_bad = (row_i.row_length < LenMin) || (row_i.row_length > LenMax);
  assign stuck   = ((raw[0] == AllOnes) && (raw[1] == AllOnes) && (raw[2] == AllOnes)) ||
                   ((raw[0] == '0) && (raw[1] == '0) && (raw[2] == '0));

  assign mag     = br[0][6:0] & MagMask[6:0];
  assign mag_ext = {1'b0, mag};

  always_comb begin
    res_o = '0;
    if (len_bad) begin
      res_o.outcome = OUT_BAD_LEN;
    end else if (stuck) begin
      res_o.outcome = OUT_STUCK;
    end else if ((crc_calc != br[4]) && (crc_calc != (br[4] | CrcFix))) begin
      res_o.outcome = OUT_CRC_FAIL;
    end else begin
      res_o.outcome       = OUT_VALID;
      // accept a frame whose last bit went missing
      res_o.crc_repaired  = (crc_calc != br[4]);
      res_o.node_id       = {br[1], br[2]};
      res_o.channel       = {1'b0, br[3][0]} + 2'd1;
      res_o.batt_good     = ~br[3][1];
      res_o.status_bits   = br[3][7:1];
      res_o.temp_degf     = br[0][7] ? (8'd0 - mag_ext) : mag_ext;
    end
  end

endmodule

// ----- rtl/fsfd_checker.sv -----
module fsfd_checker import fsfd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input fsfd_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input fsfd_out_t out_data_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled row changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result side free");

  a_reject_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.outcome != OUT_VALID) |->
      (out_data_o.crc_repaired == 1'b0) && (out_data_o.node_id == '0) &&
      (out_data_o.channel == '0) && (out_data_o.batt_good == 1'b0) &&
      (out_data_o.status_bits == '0) && (out_data_o.temp_degf == '0))
    else $error("rejected row carries data");

  a_valid_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.outcome == OUT_VALID) |->
      ((out_data_o.channel == 2'd1) || (out_data_o.channel == 2'd2)) &&
      (out_data_o.batt_good != out_data_o.status_bits[0]) &&
      (out_data_o.temp_degf != 8'sh80))
    else $error("accepted row fields inconsistent");

endmodule

bind fridge_sensor_frame_decoder_unit fsfd_checker u_fsfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

import fsfd_pkg::*;

function automatic logic [7:0] rev8(input logic [7:0] v);
  logic [7:0] r;
  for (int i = 0; i < 8; i++) begin
    r[7-i] = v[i];
  end
  return r;
endfunction

// Reflected CRC-8, one message bit at a time, LSB of each byte first.
function automatic logic [7:0] frame_crc(input logic [7:0] d0, input logic [7:0] d1,
                                         input logic [7:0] d2, input logic [7:0] d3);
  logic [31:0] msg;
  logic [7:0]  rem;
  logic [7:0]  poly_r;
  logic        fb;
  msg    = {d3, d2, d1, d0};
  rem    = 8'h00;
  poly_r = rev8(CrcPoly);
  for (int i = 0; i < 32; i++) begin
    fb  = rem[0] ^ msg[i];
    rem = rem >> 1;
    if (fb) begin
      rem = rem ^ poly_r;
    end
  end
  return rem;
endfunction

// Holds the decoded frames still owed by the block and checks each result
// against the oldest of them.
class frame_scoreboard;
  fsfd_out_t expected_frames[$];
  int unsigned errors;

  function new();
    errors = 0;
  endfunction

  function fsfd_out_t decode_frame(input fsfd_in_t row);
    fsfd_out_t  res;
    logic [7:0] raw [5];
    logic [7:0] br [5];
    logic [7:0] crc;
    logic [7:0] mag;
    res = '0;
    if (row.row_length < LenMin || row.row_length > LenMax) begin
      res.outcome = OUT_BAD_LEN;
      return res;
    end
    for (int i = 0; i < 5; i++) begin
      raw[i] = row.row_bits[39-8*i -: 8];
      br[i]  = rev8(raw[i]);
    end
    if ((raw[0] == AllOnes && raw[1] == AllOnes && raw[2] == AllOnes) ||
        (raw[0] == 8'h00 && raw[1] == 8'h00 && raw[2] == 8'h00)) begin
      res.outcome = OUT_STUCK;
      return res;
    end
    crc = frame_crc(br[0], br[1], br[2], br[3]);
    if (crc != br[4]) begin
      if (crc == (br[4] | CrcFix)) begin
        res.crc_repaired = 1'b1;
      end else begin
        res.outcome = OUT_CRC_FAIL;
        return res;
      end
    end
    // sign-magnitude; a set sign with zero magnitude still gives 0
    mag = br[0] & MagMask;
    res.outcome       = OUT_VALID;
    res.node_id       = {br[1], br[2]};
    res.channel       = {1'b0, br[3][0]} + 2'd1;
    res.batt_good     = ~br[3][1];
    res.status_bits   = br[3][7:1];
    res.temp_degf     = br[0][7] ? (8'd0 - mag) : mag;
    return res;
  endfunction

  function void report(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endfunction

  function void note_row(input fsfd_in_t row);
    expected_frames.push_back(decode_frame(row));
  endfunction

  function void check_result(input fsfd_out_t got);
    fsfd_out_t want;
    if (expected_frames.size() == 0) begin
      report("result with no row outstanding");
      return;
    end
    want = expected_frames.pop_front();
    if (got.outcome !== want.outcome)
      report($sformatf("outcome %0d, want %0d", got.outcome, want.outcome));
    if (got.crc_repaired !== want.crc_repaired)
      report($sformatf("crc_repaired %0b, want %0b", got.crc_repaired, want.crc_repaired));
    if (got.node_id !== want.node_id)
      report($sformatf("node_id %h, want %h", got.node_id, want.node_id));
    if (got.channel !== want.channel)
      report($sformatf("channel %0d, want %0d", got.channel, want.channel));
    if (got.batt_good !== want.batt_good)
      report($sformatf("batt_good %0b, want %0b", got.batt_good, want.batt_good));
    if (got.status_bits !== want.status_bits)
      report($sformatf("status_bits %h, want %h", got.status_bits, want.status_bits));
    if (got.temp_degf !== want.temp_degf)
      report($sformatf("temp_degf %0d, want %0d", got.temp_degf,
                       want.temp_degf));
  endfunction

  function int pending();
    return expected_frames.size();
  endfunction
endclass

module testbench;

  typedef enum int {CRC_GOOD, CRC_FIXED, CRC_BAD} crc_mode_e;

  localparam int unsigned NumRandom  = 1750;
  localparam int unsigned StallLimit = 2000;

  logic      clk;
  logic      rst_n;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  fsfd_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  fsfd_out_t out_data;

  logic        steady = 1'b0;
  int unsigned quiet_cycles = 0;

  frame_scoreboard sb;

  fridge_sensor_frame_decoder_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit idle_now();
    return !steady && ($urandom_range(0, 99) < 27);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Build a row from decoded bytes; the CRC byte follows the requested mode.
  function automatic fsfd_in_t make_row(input logic [9:0] len, input logic [7:0] b0,
                                        input logic [7:0] b1, input logic [7:0] b2,
                                        input logic [7:0] b3, input crc_mode_e mode);
    fsfd_in_t   row;
    logic [7:0] crc;
    logic [7:0] rx;
    logic [7:0] flip;
    crc = frame_crc(b0, b1, b2, b3);
    // a repairable frame needs bit 7 of the CRC set: walk the status byte
    while (mode == CRC_FIXED && !crc[7]) begin
      b3  = b3 + 8'd1;
      crc = frame_crc(b0, b1, b2, b3);
    end
    case (mode)
      CRC_GOOD:  rx = crc;
      CRC_FIXED: rx = crc & MagMask;
      default: begin
        flip = rand_byte();
        if (flip == 8'h00 || flip == CrcFix) begin
          flip = 8'h01;
        end
        rx = crc ^ flip;
      end
    endcase
    row.row_length = len;
    row.row_bits   = {rev8(b0), rev8(b1), rev8(b2), rev8(b3), rev8(rx)};
    return row;
  endfunction

  function automatic fsfd_in_t raw_row(input logic [9:0] len, input logic [39:0] bits);
    fsfd_in_t row;
    row.row_length = len;
    row.row_bits   = bits;
    return row;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_row(input fsfd_in_t row);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= row;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random_row();
    int unsigned pick;
    logic [9:0]  len;
    logic [39:0] bits;
    crc_mode_e   mode;
    pick = $urandom_range(0, 99);
    len  = 10'($urandom_range(39, 43));
    bits = {8'($urandom), $urandom};
    if (pick < 70) begin
      case ($urandom_range(0, 3))
        0, 1:    mode = CRC_GOOD;
        2:       mode = CRC_FIXED;
        default: mode = CRC_BAD;
      endcase
      send_row(make_row(len, rand_byte(), rand_byte(), rand_byte(), rand_byte(), mode));
    end else if (pick < 82) begin
      // stuck preamble, occasionally with a bad length as well
      if ($urandom_range(0, 4) == 0) begin
        len = 10'($urandom_range(0, 1023));
      end
      bits[39:16] = {24{bits[0]}};
      send_row(raw_row(len, bits));
    end else if (pick < 92) begin
      send_row(raw_row(10'($urandom_range(0, 1023)), bits));
    end else begin
      send_row(raw_row(len, bits));
    end
  endtask

  always @(negedge clk) begin
    out_stall <= idle_now();
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_row(in_data);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
      end
    end
  end

  // Drop out when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    sb    = new();
    rst_n = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // plain frames: both channels, battery states and temperature extremes
    send_row(make_row(10'd40, 8'h45, 8'h12, 8'h34, 8'h00, CRC_GOOD));
    send_row(make_row(10'd41, 8'hc5, 8'hab, 8'hcd, 8'h03, CRC_GOOD));
    send_row(make_row(10'd42, 8'h80, 8'h5a, 8'ha5, 8'h01, CRC_GOOD));
    send_row(make_row(10'd43, 8'hff, 8'h00, 8'h5a, 8'hfe, CRC_GOOD));
    send_row(make_row(10'd40, 8'h7f, 8'hff, 8'hff, 8'hff, CRC_GOOD));
    send_row(make_row(10'd41, 8'h00, 8'h00, 8'h01, 8'h00, CRC_GOOD));
    // short row, the missing-last-bit repair and a bad CRC
    send_row(make_row(10'd39, 8'h3c, 8'h81, 8'h7e, 8'h42, CRC_FIXED));
    send_row(make_row(10'd42, 8'h96, 8'h24, 8'h18, 8'h10, CRC_FIXED));
    send_row(make_row(10'd39, 8'h21, 8'h43, 8'h65, 8'h87, CRC_GOOD));
    send_row(make_row(10'd40, 8'h11, 8'h22, 8'h33, 8'h44, CRC_BAD));
    // length bounds, checked ahead of everything else
    send_row(make_row(10'd0, 8'h45, 8'h12, 8'h34, 8'h00, CRC_GOOD));
    send_row(make_row(10'd38, 8'h45, 8'h12, 8'h34, 8'h00, CRC_GOOD));
    send_row(make_row(10'd44, 8'h45, 8'h12, 8'h34, 8'h00, CRC_GOOD));
    send_row(make_row(10'd1023, 8'h45, 8'h12, 8'h34, 8'h00, CRC_GOOD));
    send_row(raw_row(10'd512, 40'hff_ffff_ffff));
    // stuck preambles, and one that just misses
    send_row(raw_row(10'd40, 40'hff_ffff_0000));
    send_row(raw_row(10'd43, 40'h00_0000_1234));
    send_row(raw_row(10'd39, 40'h00_0000_0000));
    send_row(raw_row(10'd43, 40'hff_ffff_ffff));
    send_row(make_row(10'd41, 8'hff, 8'hff, 8'h7f, 8'h55, CRC_GOOD));

    for (int unsigned i = 0; i < NumRandom; i++) begin
      steady = (i >= 800 && i < 1100);
      send_random_row();
    end
    steady   = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
